### rtl/rsti_pkg.sv
package rsti_pkg;

  localparam int unsigned MagWidth   = 63;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned RadixWidth = 6;

  localparam logic [CharWidth-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [CharWidth-1:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [CharWidth-1:0] CharUpZ   = 8'h5A;  // 'Z'
  localparam logic [CharWidth-1:0] CharMinus = 8'h2D;  // '-'

  localparam logic [RadixWidth-1:0] RadixReset = 6'd10;
  localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;
  localparam logic [RadixWidth-1:0] LetterBase = 6'd10;
  localparam logic [RadixWidth-1:0] NoDigit    = 6'd36;

  typedef struct packed {
    logic [MagWidth-1:0] magnitude;
    logic                negative;
    logic                at_start;
    logic                has_digit;
    logic                failed;
  } num_state_t;

  localparam num_state_t NumReset = '{
    magnitude: '0,
    negative:  1'b0,
    at_start:  1'b1,
    has_digit: 1'b0,
    failed:    1'b0
  };

  // Digit weight 0..35, or NoDigit for a character that is not a digit.
  function automatic logic [RadixWidth-1:0] weight_of(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] diff;
    diff = '0;
    if (c >= CharZero && c <= CharNine) begin
      diff = c - CharZero;
      return diff[RadixWidth-1:0];
    end else if (c >= CharUpA && c <= CharUpZ) begin
      diff = c - CharUpA;
      return diff[RadixWidth-1:0] + LetterBase;
    end
    return NoDigit;
  endfunction

endpackage

### rtl/rsti_in_if.sv
interface rsti_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink (input valid, input ch, input end_of_string, output ready);
endinterface

### rtl/rsti_out_if.sv
interface rsti_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### rtl/rsti_step.sv
module rsti_step (
  input  rsti_pkg::num_state_t                 state_i,
  input  logic [rsti_pkg::CharWidth-1:0]       ch_i,
  input  logic [rsti_pkg::RadixWidth-1:0]      radix_i,
  output rsti_pkg::num_state_t                 state_o
);
  import rsti_pkg::*;

  localparam int unsigned ProdWidth = MagWidth + RadixWidth;

  logic [RadixWidth-1:0] digit;
  logic                  bad_digit;
  logic [ProdWidth-1:0]  product;
  logic [ProdWidth-1:0]  acc;
  logic                  overflow;

  assign digit     = weight_of(ch_i);
  assign bad_digit = (radix_i < RadixMin) || (radix_i > RadixMax) || (digit >= radix_i);

  // magnitude * radix + digit overflows exactly when it exceeds 2^63-1.
  assign product  = ProdWidth'(state_i.magnitude) * ProdWidth'(radix_i);
  assign acc      = product + ProdWidth'(digit);
  assign overflow = |acc[ProdWidth-1:MagWidth];

  always_comb begin
    state_o          = state_i;
    state_o.at_start = 1'b0;
    if (state_i.at_start && ch_i == CharMinus) begin
      state_o.negative = 1'b1;
    end else if (!state_i.failed) begin
      if (bad_digit || overflow) begin
        state_o.failed = 1'b1;
      end else begin
        state_o.magnitude = acc[MagWidth-1:0];
        state_o.has_digit = 1'b1;
      end
    end
  end

endmodule

### rtl/radix_string_to_integer.sv
// Timing: a character or end marker is registered on transfer; the end marker's result
// is then loaded into the output register, which drives out valid, once that register
// is empty or being read. Throughput: one item per cycle unless an end marker waits on
// a full output register; the digit multiply-accumulate is combinational.
// Reset: asynchronous, active low; clears the number state and pipeline valids and sets
// the radix register to 10.
module radix_string_to_integer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                radix_we_i,
  input  logic [rsti_pkg::RadixWidth-1:0]     radix_i,
  rsti_in_if.sink                             in_i,
  rsti_out_if.source                          out_o
);
  import rsti_pkg::*;

  logic [RadixWidth-1:0] radix_q;
  logic                  s1_valid_q;
  logic [CharWidth-1:0]  s1_ch_q;
  logic                  s1_eos_q;
  num_state_t            num_q;
  num_state_t            num_d;
  logic                  out_valid_q;
  logic [ValueWidth-1:0] value_q;
  logic [ValueWidth-1:0] value_d;
  logic                  status_q;
  logic                  status_d;
  logic                  s1_stall;
  logic                  s1_adv;
  logic                  in_xfer;

  rsti_step u_step (
    .state_i (num_q),
    .ch_i    (s1_ch_q),
    .radix_i (radix_q),
    .state_o (num_d)
  );

  // Only a pending end marker waits on a full output register; characters never stall.
  assign s1_stall = s1_valid_q && s1_eos_q && out_valid_q && !out_o.ready;
  assign s1_adv   = s1_valid_q && !s1_stall;
  assign in_i.ready = !s1_stall;
  assign in_xfer  = in_i.valid && !s1_stall;

  always_comb begin
    if (num_q.failed || !num_q.has_digit) begin
      status_d = 1'b1;
      value_d  = '0;
    end else begin
      status_d = 1'b0;
      value_d  = num_q.negative ? (ValueWidth'(0) - ValueWidth'(num_q.magnitude))
                                : ValueWidth'(num_q.magnitude);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      s1_valid_q  <= 1'b0;
      num_q       <= NumReset;
      out_valid_q <= 1'b0;
    end else begin
      if (radix_we_i) begin
        radix_q <= radix_i;
      end
      if (!s1_stall) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        num_q <= s1_eos_q ? NumReset : num_d;
      end
      if (s1_adv && s1_eos_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q  <= in_i.ch;
      s1_eos_q <= in_i.end_of_string;
    end
    if (s1_adv && s1_eos_q) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = value_q;
  assign out_o.status = status_q;

endmodule

### tb/tb_radix_string_to_integer.sv
`timescale 1ns / 100ps

module tb_radix_string_to_integer;
  import rsti_pkg::*;

  localparam int IdleLimit = 2000;
  localparam logic [63:0] MagLimit = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 eos;
  } text_item_t;

  typedef struct {
    logic signed [ValueWidth-1:0] value;
    logic                         status;
  } parse_result_t;

  typedef enum {PaceFull, PaceRandom, PacePeriodic, PaceSparse} pace_mode_e;

  logic clk;
  logic rst_n;
  logic radix_we;
  logic [RadixWidth-1:0] radix_wdata;

  rsti_in_if  in_ch ();
  rsti_out_if out_ch ();

  radix_string_to_integer i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .radix_we_i (radix_we),
    .radix_i    (radix_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  text_item_t    char_q[$];
  parse_result_t parsed_q[$];
  int items_sent = 0;
  int items_outstanding = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  // Shadow of the radix register and of the number being parsed.
  logic [RadixWidth-1:0] cur_radix = RadixReset;
  logic [MagWidth-1:0]   num_mag = '0;
  logic                  num_neg = 1'b0;
  logic                  num_fresh = 1'b1;
  logic                  num_has_digit = 1'b0;
  logic                  num_bad = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CharWidth-1:0] digit_char(int w);
    if (w < 10) return CharWidth'(int'(CharZero) + w);
    return CharWidth'(int'(CharUpA) + (w - 10));
  endfunction

  function automatic int digit_weight(logic [CharWidth-1:0] c);
    if (c >= CharZero && c <= CharNine) return int'(c) - int'(CharZero);
    if (c >= CharUpA && c <= CharUpZ) return int'(c) - int'(CharUpA) + 10;
    return 36;
  endfunction

  function automatic void take_item(text_item_t it);
    logic        was_fresh;
    int          w;
    logic [63:0] headroom;
    logic [63:0] grown;
    parse_result_t res;
    if (!it.eos) begin
      was_fresh = num_fresh;
      num_fresh = 1'b0;
      if (was_fresh && it.ch == CharMinus) begin
        num_neg = 1'b1;
      end else if (!num_bad) begin
        w = digit_weight(it.ch);
        if (cur_radix < RadixMin || cur_radix > RadixMax || w >= int'(cur_radix)) begin
          num_bad = 1'b1;
        end else begin
          headroom = (MagLimit - 64'(w)) / 64'(cur_radix);
          if ({1'b0, num_mag} > headroom) begin
            num_bad = 1'b1;
          end else begin
            grown = {1'b0, num_mag} * 64'(cur_radix) + 64'(w);
            num_mag = grown[MagWidth-1:0];
            num_has_digit = 1'b1;
          end
        end
      end
    end else begin
      if (num_bad || !num_has_digit) begin
        res.value = '0;
        res.status = 1'b1;
      end else begin
        res.value = num_neg ? 64'(0) - {1'b0, num_mag} : {1'b0, num_mag};
        res.status = 1'b0;
      end
      parsed_q.push_back(res);
      num_mag = '0;
      num_neg = 1'b0;
      num_fresh = 1'b1;
      num_has_digit = 1'b0;
      num_bad = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic signed [63:0] got,
                                 logic signed [63:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_char(logic [CharWidth-1:0] c);
    char_q.push_back('{ch: c, eos: 1'b0});
    items_sent++;
    items_outstanding++;
  endtask

  task automatic send_end();
    // The character under an end marker is ignored, so it is left random.
    char_q.push_back('{ch: CharWidth'($urandom_range(0, 255)), eos: 1'b1});
    items_sent++;
    items_outstanding++;
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_end();
  endtask

  task automatic add_number();
    logic [CharWidth-1:0] text[$];
    logic [CharWidth-1:0] digs[$];
    logic [63:0] v;
    logic radix_ok;
    int kind, n, pos, pick;
    radix_ok = cur_radix >= RadixMin && cur_radix <= RadixMax;
    kind = $urandom_range(0, 99);
    if (kind < 80 && $urandom_range(0, 1) == 1) text.push_back(CharMinus);
    if (kind >= 50 && kind < 65 && radix_ok) begin
      // Values near, at or beyond the 63-bit limit, or random, written out in the current radix.
      pick = $urandom_range(0, 4);
      case (pick)
        0: v = MagLimit - 64'($urandom_range(0, 2));
        1: v = MagLimit + 64'(1 + $urandom_range(0, 2));
        2: v = {$urandom, $urandom};
        3: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        default: v = MagLimit;
      endcase
      repeat ($urandom_range(0, 2)) text.push_back(CharZero);
      if (v == 0) digs.push_back(CharZero);
      while (v != 0) begin
        digs.push_front(digit_char(int'(v % 64'(cur_radix))));
        v = v / 64'(cur_radix);
      end
      if (pick == 4) digs.push_back(digit_char($urandom_range(0, cur_radix - 1)));
      foreach (digs[i]) text.push_back(digs[i]);
    end else if (kind < 80) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
      repeat (n)
        text.push_back(digit_char(radix_ok ? $urandom_range(0, cur_radix - 1)
                                           : $urandom_range(0, 35)));
      if (kind >= 65) begin
        pos = $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 4))
          0: text[pos] = CharWidth'($urandom_range(0, 255));
          1: text[pos] = CharWidth'(8'h61 + $urandom_range(0, 25));
          2: text[pos] = CharMinus;
          3: begin
            case ($urandom_range(0, 3))
              0: text[pos] = CharZero - 8'd1;
              1: text[pos] = CharNine + 8'd1;
              2: text[pos] = CharUpA - 8'd1;
              default: text[pos] = CharUpZ + 8'd1;
            endcase
          end
          default: begin
            if (radix_ok && cur_radix < RadixMax)
              text[pos] = digit_char($urandom_range(cur_radix, 35));
          end
        endcase
      end
    end else if (kind < 88) begin
      if ($urandom_range(0, 1) == 1) text.push_back(CharMinus);
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back(CharWidth'($urandom_range(0, 255)));
    end
    foreach (text[i]) send_char(text[i]);
    send_end();
  endtask

  task automatic wait_all_parsed();
    while (items_outstanding != 0 || parsed_q.size() != 0) @(posedge clk);
    // A trailing character may still be in the pipeline with no result to show for it.
    repeat (4) @(posedge clk);
  endtask

  // Character source: bursts of transfers separated by random gaps.
  always @(posedge clk) begin : drive_chars
    text_item_t nxt;
    logic load;
    int burst_left;
    int gap_left;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.ch <= '0;
      in_ch.end_of_string <= 1'b0;
      burst_left = 8;
      gap_left = 0;
    end else begin
      load = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        take_item('{ch: in_ch.ch, eos: in_ch.end_of_string});
        items_outstanding--;
      end
      // A waiting item holds its valid and payload until it is taken.
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() > 0) begin
          nxt = char_q.pop_front();
          load = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(5, 25);
            else gap_left = $urandom_range(1, 3);
          end
        end
        in_ch.valid <= load;
        if (load) begin
          in_ch.ch <= nxt.ch;
          in_ch.end_of_string <= nxt.eos;
        end
      end
    end
  end

  // Result sink: switches between randomly chosen stall patterns.
  always @(posedge clk) begin : pace_results
    pace_mode_e mode;
    int mode_left;
    int period;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mode = PaceFull;
      mode_left = 0;
      period = 2;
    end else begin
      if (mode_left <= 0) begin
        mode = pace_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
        period = $urandom_range(2, 5);
      end
      mode_left--;
      case (mode)
        PaceFull:     out_ch.ready <= 1'b1;
        PaceRandom:   out_ch.ready <= ($urandom_range(0, 9) < 7);
        PacePeriodic: out_ch.ready <= (mode_left % period) != 0;
        default:      out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (parsed_q.size() == 0) begin
        report_mismatch("result with no end marker pending", out_ch.value, 0);
      end else begin
        want = parsed_q.pop_front();
        if (out_ch.value !== want.value)
          report_mismatch("value", out_ch.value, want.value);
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("tb_radix_string_to_integer failed");
    $finish;
  end

  initial begin
    int radix_plan[13];
    int phase_end;
    radix_plan = '{2, 36, 16, 0, 8, 63, 1, 37, 35, 3, 10, 7, 0};
    rst_n = 1'b0;
    radix_we <= 1'b0;
    radix_wdata <= RadixReset;
    radix_plan[12] = $urandom_range(RadixMin, RadixMax);

    // Directed strings at the reset radix of ten.
    send_string("");
    send_string("-");
    send_string("0");
    send_string("-7");
    send_string("5-");
    send_string("A");
    send_string("12a4");
    send_char(8'h00);
    send_end();
    send_char(CharNine);
    send_char(8'hFF);
    send_char(8'h33);
    send_end();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (radix_plan[p]) begin
      wait_all_parsed();
      radix_wdata <= RadixWidth'(radix_plan[p]);
      radix_we <= 1'b1;
      @(posedge clk);
      radix_we <= 1'b0;
      cur_radix = RadixWidth'(radix_plan[p]);
      phase_end = items_sent + 80;
      while (items_sent < phase_end) add_number();
    end

    wait_all_parsed();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_radix_string_to_integer passed");
    else
      $display("tb_radix_string_to_integer failed");
    $finish;
  end

endmodule
